@@ hw/rtl/rvtp_pkg.sv @@
// Shared types and constants for the rate/voltage table patcher.
// Used by the top level and by the voltage arithmetic unit; no dependencies.
`timescale 1ns / 1ps

package rvtp_pkg;

  localparam int RATE_W = 26;
  localparam int VOLT_W = 21;

  // Voltage arithmetic: steps of 6250 uV, values above ABS_LIMIT are absolute.
  localparam int unsigned STEP_UV     = 6250;
  localparam int unsigned ABS_LIMIT   = 10000;
  localparam int unsigned VOLT_MAX    = 2097151;
  // floor(x / 6250) == (x * RECIP_M) >> RECIP_SHIFT for every x below 2953904,
  // which covers every voltage plus the rounding offset of 6249.
  localparam int unsigned RECIP_M     = 2748780;
  localparam int          RECIP_SHIFT = 34;
  localparam int          Q_W         = 14;  // holds a step count up to 10000
  localparam int          QA_W        = 10;  // holds a rounded absolute quotient

  typedef enum logic [1:0] {
    KIND_PATCH  = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_READ   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_UPDATED   = 3'd0,
    ST_DELETED   = 3'd1,
    ST_INSERTED  = 3'd2,
    ST_APPENDED  = 3'd3,
    ST_READ      = 3'd4,
    ST_ZERO_RATE = 3'd5,
    ST_FULL      = 3'd6,
    ST_BAD_INDEX = 3'd7
  } status_t;

  typedef struct packed {
    logic              go;
    logic [VOLT_W-1:0] base;
    logic [VOLT_W-1:0] volt;
  } volt_req_t;

  typedef struct packed {
    logic              done;
    logic [VOLT_W-1:0] value;
  } volt_resp_t;

endpackage

@@ hw/rtl/rvtp_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module rvtp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/rvtp_volt_unit.sv @@
// Two-stage voltage arithmetic: rounds an absolute value up to a 6250 uV step,
// or adds a step count to a base, with saturation. Depends on rvtp_pkg.
`timescale 1ns / 1ps

module rvtp_volt_unit
  import rvtp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  volt_req_t  req,
  output volt_resp_t resp
);

  logic              s1_valid;
  logic              s1_abs;
  logic [Q_W-1:0]    s1_q;
  logic [VOLT_W-1:0] s1_base;

  logic              is_abs;
  logic [VOLT_W:0]   v_round;
  logic [43:0]       prod1;
  logic [QA_W-1:0]   q_abs;
  logic [26:0]       prod2;
  logic [27:0]       sum;
  logic [VOLT_W-1:0] sat;

  // Ceiling division by the step size through a reciprocal multiply.
  assign is_abs  = req.volt > VOLT_W'(ABS_LIMIT);
  assign v_round = {1'b0, req.volt} + (VOLT_W + 1)'(STEP_UV - 1);
  assign prod1   = 44'(v_round) * 44'(RECIP_M);
  assign q_abs   = prod1[RECIP_SHIFT +: QA_W];

  assign prod2 = 27'(s1_q) * 27'(STEP_UV);
  assign sum   = s1_abs ? 28'(prod2) : 28'(s1_base) + 28'(prod2);
  assign sat   = (sum > 28'(VOLT_MAX)) ? VOLT_W'(VOLT_MAX) : sum[VOLT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      resp.done <= 1'b0;
    end else begin
      s1_valid  <= req.go;
      resp.done <= s1_valid;
      if (req.go) begin
        s1_abs  <= is_abs;
        s1_q    <= is_abs ? Q_W'(q_abs) : req.volt[Q_W-1:0];
        s1_base <= req.base;
      end
      if (s1_valid) begin
        resp.value <= sat;
      end
    end
  end

endmodule

@@ hw/rtl/rate_voltage_table_patcher.sv @@
// Top level of the rate/voltage table patcher: sequencer, level counts and
// the two level memories. Depends on rvtp_pkg, rvtp_ram and rvtp_volt_unit.
`timescale 1ns / 1ps
//
// Channel   Direction  Handshake              Payload
// item      in         start & !busy          kind, domain, rate, volt, level_index
// result    out        done (one-cycle pulse) status, level_count, entry_rate, entry_volt
//
// A read issues its memory read in S_DISPATCH and reports from S_RDWAIT if its index
// is in range; an append writes if not full and reports in S_DISPATCH. A patch searches
// the table one entry per cycle through the registered memory read. An update then goes
// through the voltage unit; an insert or delete shifts entries one per cycle, and an
// insert with a nonzero voltage then goes through the voltage unit.
// Reset clears the level counts; memory contents are not cleared.
// The result is presented for one cycle and cannot be stalled; a new item is
// taken from the cycle in which the previous result is shown.

module rate_voltage_table_patcher
  import rvtp_pkg::*;
#(
  parameter int DOMAINS = 16,
  parameter int LEVELS  = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        kind,
  input  logic [3:0]        domain,
  input  logic [RATE_W-1:0] rate,
  input  logic [VOLT_W-1:0] volt,
  input  logic [4:0]        level_index,
  output logic              done,
  output logic [2:0]        status,
  output logic [5:0]        level_count,
  output logic [RATE_W-1:0] entry_rate,
  output logic [VOLT_W-1:0] entry_volt
);

  localparam int DEPTH = DOMAINS * LEVELS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(LEVELS + 1);
  localparam int DIW   = (DOMAINS > 1) ? $clog2(DOMAINS) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_RDWAIT, S_SEARCH, S_DECIDE,
    S_SHIFT, S_VSTART, S_VWAIT, S_FINISH
  } state_t;

  typedef enum logic [1:0] {
    OP_UPDATE, OP_DELETE, OP_INSERT
  } op_t;

  state_t state;
  op_t    op;

  logic [1:0]        kind_r;
  logic [3:0]        dom_r;
  logic [RATE_W-1:0] rate_r;
  logic [VOLT_W-1:0] volt_r;
  logic [4:0]        idx_r;

  logic [CW-1:0]     counts [DOMAINS];
  logic [CW-1:0]     cnt_r;
  logic [CW-1:0]     sj, cj, fj, pos, fin_pos, n, sidx, wdst;
  logic              cv, found, pos_set, dir_up, wp;
  logic [VOLT_W-1:0] fvolt, base_v, vbase, nv;

  logic [DIW-1:0]    dom_idx;
  logic [CW-1:0]     cnt_cur;
  logic              dom_bad;

  logic              we, re;
  logic [AW-1:0]     waddr, raddr;
  logic [RATE_W-1:0] wrate, rdata_rate;
  logic [VOLT_W-1:0] wvolt, rdata_volt;

  volt_req_t  vreq;
  volt_resp_t vresp;

  function automatic logic [AW-1:0] addr_of(input logic [3:0] d, input logic [CW-1:0] j);
    addr_of = AW'(AW'(d) * AW'(LEVELS)) + AW'(j);
  endfunction

  assign busy    = (state != S_IDLE);
  assign dom_idx = DIW'(dom_r);
  assign cnt_cur = counts[dom_idx];
  assign dom_bad = 7'(dom_r) >= 7'(DOMAINS);

  // Memory port control.
  always_comb begin
    re    = 1'b0;
    raddr = addr_of(dom_r, sj);
    we    = 1'b0;
    waddr = addr_of(dom_r, wdst);
    wrate = rdata_rate;
    wvolt = rdata_volt;
    case (state)
      S_DISPATCH: begin
        if (kind_r == KIND_READ) begin
          re    = 1'b1;
          raddr = addr_of(dom_r, CW'(idx_r));
        end else if (kind_r == KIND_APPEND && !dom_bad && cnt_cur < CW'(LEVELS)) begin
          we    = 1'b1;
          waddr = addr_of(dom_r, cnt_cur);
          wrate = rate_r;
          wvolt = volt_r;
        end
      end
      S_SEARCH: begin
        re = (sj != cnt_r);
      end
      S_SHIFT: begin
        re    = (n != '0);
        raddr = addr_of(dom_r, sidx);
        we    = wp;
      end
      S_FINISH: begin
        we    = 1'b1;
        waddr = addr_of(dom_r, fin_pos);
        wrate = rate_r;
        wvolt = nv;
      end
      default: begin
      end
    endcase
  end

  assign vreq.go   = (state == S_VSTART);
  assign vreq.base = vbase;
  assign vreq.volt = volt_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      for (int d = 0; d < DOMAINS; d++) begin
        counts[d] <= '0;
      end
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            kind_r <= kind;
            dom_r  <= domain;
            rate_r <= rate;
            volt_r <= volt;
            idx_r  <= level_index;
            state  <= S_DISPATCH;
          end
        end

        S_DISPATCH: begin
          cnt_r   <= cnt_cur;
          sj      <= '0;
          cv      <= 1'b0;
          found   <= 1'b0;
          pos_set <= 1'b0;
          state   <= S_IDLE;
          if (dom_bad || !(kind_r == KIND_PATCH || kind_r == KIND_APPEND ||
                           kind_r == KIND_READ)) begin
            done        <= 1'b1;
            status      <= ST_BAD_INDEX;
            level_count <= '0;
            entry_rate  <= '0;
            entry_volt  <= '0;
          end else begin
            case (kind_r)
              KIND_READ: begin
                if (7'(idx_r) >= 7'(cnt_cur)) begin
                  done        <= 1'b1;
                  status      <= ST_BAD_INDEX;
                  level_count <= 6'(cnt_cur);
                  entry_rate  <= '0;
                  entry_volt  <= '0;
                end else begin
                  state <= S_RDWAIT;
                end
              end
              KIND_APPEND: begin
                done       <= 1'b1;
                entry_rate <= rate_r;
                if (cnt_cur >= CW'(LEVELS)) begin
                  status      <= ST_FULL;
                  level_count <= 6'(cnt_cur);
                  entry_volt  <= '0;
                end else begin
                  status           <= ST_APPENDED;
                  level_count      <= 6'(CW'(cnt_cur + CW'(1)));
                  entry_volt       <= volt_r;
                  counts[dom_idx]  <= CW'(cnt_cur + CW'(1));
                end
              end
              default: begin
                if (rate_r == '0) begin
                  done        <= 1'b1;
                  status      <= ST_ZERO_RATE;
                  level_count <= 6'(cnt_cur);
                  entry_rate  <= '0;
                  entry_volt  <= '0;
                end else begin
                  state <= S_SEARCH;
                end
              end
            endcase
          end
        end

        S_RDWAIT: begin
          done        <= 1'b1;
          status      <= ST_READ;
          level_count <= 6'(cnt_r);
          entry_rate  <= rdata_rate;
          entry_volt  <= rdata_volt;
          state       <= S_IDLE;
        end

        // One entry per cycle: the read issued last cycle is compared now.
        S_SEARCH: begin
          if (cv && rdata_rate == rate_r) begin
            found <= 1'b1;
            fj    <= cj;
            fvolt <= rdata_volt;
            state <= S_DECIDE;
          end else begin
            if (cv && !pos_set && rdata_rate < rate_r) begin
              pos_set <= 1'b1;
              pos     <= cj;
              base_v  <= rdata_volt;
            end
            if (sj == cnt_r) begin
              state <= S_DECIDE;
            end else begin
              cv <= 1'b1;
              cj <= sj;
              sj <= CW'(sj + CW'(1));
            end
          end
        end

        S_DECIDE: begin
          wp <= 1'b0;
          if (found) begin
            if (volt_r != '0) begin
              op      <= OP_UPDATE;
              vbase   <= fvolt;
              fin_pos <= fj;
              state   <= S_VSTART;
            end else begin
              op     <= OP_DELETE;
              nv     <= fvolt;
              n      <= CW'(cnt_r - CW'(1) - fj);
              sidx   <= CW'(fj + CW'(1));
              dir_up <= 1'b1;
              state  <= S_SHIFT;
            end
          end else if (cnt_r >= CW'(LEVELS)) begin
            done        <= 1'b1;
            status      <= ST_FULL;
            level_count <= 6'(cnt_r);
            entry_rate  <= rate_r;
            entry_volt  <= '0;
            state       <= S_IDLE;
          end else begin
            op      <= OP_INSERT;
            fin_pos <= pos_set ? pos : cnt_r;
            vbase   <= pos_set ? base_v : '0;
            n       <= pos_set ? CW'(cnt_r - pos) : '0;
            sidx    <= CW'(cnt_r - CW'(1));
            dir_up  <= 1'b0;
            state   <= S_SHIFT;
          end
        end

        // Pipelined move: read the source now, write it one slot over next cycle.
        S_SHIFT: begin
          if (n != '0) begin
            wp   <= 1'b1;
            wdst <= dir_up ? CW'(sidx - CW'(1)) : CW'(sidx + CW'(1));
            sidx <= dir_up ? CW'(sidx + CW'(1)) : CW'(sidx - CW'(1));
            n    <= CW'(n - CW'(1));
          end else begin
            wp <= 1'b0;
            if (!wp) begin
              if (op == OP_DELETE) begin
                done            <= 1'b1;
                status          <= ST_DELETED;
                level_count     <= 6'(CW'(cnt_r - CW'(1)));
                entry_rate      <= rate_r;
                entry_volt      <= nv;
                counts[dom_idx] <= CW'(cnt_r - CW'(1));
                state           <= S_IDLE;
              end else if (volt_r != '0) begin
                state <= S_VSTART;
              end else begin
                nv    <= vbase;
                state <= S_FINISH;
              end
            end
          end
        end

        S_VSTART: begin
          state <= S_VWAIT;
        end

        S_VWAIT: begin
          if (vresp.done) begin
            nv    <= vresp.value;
            state <= S_FINISH;
          end
        end

        S_FINISH: begin
          done       <= 1'b1;
          entry_rate <= rate_r;
          entry_volt <= nv;
          state      <= S_IDLE;
          if (op == OP_INSERT) begin
            status          <= ST_INSERTED;
            level_count     <= 6'(CW'(cnt_r + CW'(1)));
            counts[dom_idx] <= CW'(cnt_r + CW'(1));
          end else begin
            status      <= ST_UPDATED;
            level_count <= 6'(cnt_r);
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  rvtp_ram #(
    .WIDTH(RATE_W),
    .DEPTH(DEPTH)
  ) u_rate_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wrate),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata_rate)
  );

  rvtp_ram #(
    .WIDTH(VOLT_W),
    .DEPTH(DEPTH)
  ) u_volt_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wvolt),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata_volt)
  );

  rvtp_volt_unit u_volt (
    .clk (clk),
    .rst (rst),
    .req (vreq),
    .resp(vresp)
  );

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not leave idle");

  a_result_ends_work: assert property (@(posedge clk) disable iff (rst)
    done |-> (!busy && $past(busy)))
    else $error("result strobe outside the end of a transaction");

  a_shift_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT && we && re) |-> (waddr != raddr))
    else $error("shift reads and writes the same entry in one cycle");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == S_DISPATCH && !dom_bad) |-> (cnt_cur <= CW'(LEVELS)))
    else $error("level count above table size");

  a_volt_done_waited: assert property (@(posedge clk) disable iff (rst)
    vresp.done |-> (state == S_VWAIT))
    else $error("voltage result arrived outside its wait state");

endmodule

@@ tb/sv/rate_voltage_table_patcher_tb.sv @@
// Self-checking testbench for rate_voltage_table_patcher: directed and random
// patch, append and read transactions checked against a tracked copy of the tables.
// Depends on rvtp_pkg and the block's RTL.
`timescale 1ns / 1ps

module rate_voltage_table_patcher_tb;
  import rvtp_pkg::*;

  localparam int DOMAINS = 16;
  localparam int LEVELS  = 32;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [RATE_W-1:0] RATE_TOP = {RATE_W{1'b1}};
  localparam logic [VOLT_W-1:0] VOLT_TOP = {VOLT_W{1'b1}};

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [1:0]        kind;
  logic [3:0]        domain;
  logic [RATE_W-1:0] rate;
  logic [VOLT_W-1:0] volt;
  logic [4:0]        level_index;
  logic              done;
  logic [2:0]        status;
  logic [5:0]        level_count;
  logic [RATE_W-1:0] entry_rate;
  logic [VOLT_W-1:0] entry_volt;

  // Keeps its own copy of every level table and the results still owed.
  class level_table_tracker;
    typedef struct packed {
      status_t           st;
      logic [5:0]        cnt;
      logic [RATE_W-1:0] r;
      logic [VOLT_W-1:0] v;
    } level_outcome_t;

    logic [RATE_W-1:0] rate_tab [DOMAINS][LEVELS];
    logic [VOLT_W-1:0] volt_tab [DOMAINS][LEVELS];
    int unsigned       fill [DOMAINS];
    level_outcome_t    owed [$];
    int unsigned       mismatches;

    function new();
      foreach (fill[d]) fill[d] = 0;
      mismatches = 0;
    endfunction

    // Absolute values are rounded up to the next step; small values add steps.
    function logic [VOLT_W-1:0] patched_volt(logic [VOLT_W-1:0] cur,
                                             logic [VOLT_W-1:0] v);
      longint unsigned sum;
      longint unsigned rem;
      if (v > ABS_LIMIT) begin
        rem = longint'(v) % STEP_UV;
        sum = longint'(v) + ((rem != 0) ? (STEP_UV - rem) : 0);
      end else begin
        sum = longint'(cur) + longint'(v) * STEP_UV;
      end
      if (sum > VOLT_MAX) sum = VOLT_MAX;
      return sum[VOLT_W-1:0];
    endfunction

    function void note_item(logic [1:0] k, logic [3:0] d, logic [RATE_W-1:0] r,
                            logic [VOLT_W-1:0] v, logic [4:0] idx);
      level_outcome_t o;
      int unsigned cnt;
      int j;
      int pos;
      bit found;
      logic [VOLT_W-1:0] nv;
      o = '0;
      o.st = ST_BAD_INDEX;
      cnt = fill[d];
      found = 0;
      j = 0;
      case (k)
        KIND_READ: begin
          o.cnt = cnt[5:0];
          if (idx < cnt) begin
            o.st = ST_READ;
            o.r  = rate_tab[d][idx];
            o.v  = volt_tab[d][idx];
          end
        end
        KIND_APPEND: begin
          o.r = r;
          if (cnt >= LEVELS) begin
            o.st  = ST_FULL;
            o.cnt = cnt[5:0];
          end else begin
            rate_tab[d][cnt] = r;
            volt_tab[d][cnt] = v;
            fill[d] = cnt + 1;
            o.st  = ST_APPENDED;
            o.cnt = fill[d][5:0];
            o.v   = v;
          end
        end
        KIND_PATCH: begin
          o.cnt = cnt[5:0];
          if (r == 0) begin
            o.st = ST_ZERO_RATE;
          end else begin
            o.r = r;
            for (j = 0; j < cnt; j++) begin
              if (rate_tab[d][j] == r) begin
                found = 1;
                break;
              end
            end
            if (found && v != 0) begin
              nv = patched_volt(volt_tab[d][j], v);
              volt_tab[d][j] = nv;
              o.st = ST_UPDATED;
              o.v  = nv;
            end else if (found) begin
              o.v = volt_tab[d][j];
              for (pos = j; pos + 1 < cnt; pos++) begin
                rate_tab[d][pos] = rate_tab[d][pos + 1];
                volt_tab[d][pos] = volt_tab[d][pos + 1];
              end
              fill[d] = cnt - 1;
              o.st  = ST_DELETED;
              o.cnt = fill[d][5:0];
            end else if (cnt >= LEVELS) begin
              o.st = ST_FULL;
            end else begin
              pos = cnt;
              for (j = 0; j < cnt; j++) begin
                if (rate_tab[d][j] < r) begin
                  pos = j;
                  break;
                end
              end
              // The new level inherits the voltage of the level it pushes down.
              nv = (pos < cnt) ? volt_tab[d][pos] : '0;
              for (j = cnt; j > pos; j--) begin
                rate_tab[d][j] = rate_tab[d][j - 1];
                volt_tab[d][j] = volt_tab[d][j - 1];
              end
              if (v != 0) nv = patched_volt(nv, v);
              rate_tab[d][pos] = r;
              volt_tab[d][pos] = nv;
              fill[d] = cnt + 1;
              o.st  = ST_INSERTED;
              o.cnt = fill[d][5:0];
              o.v   = nv;
            end
          end
        end
        default: ;
      endcase
      owed.push_back(o);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(logic [2:0] st, logic [5:0] cnt,
                               logic [RATE_W-1:0] r, logic [VOLT_W-1:0] v);
      level_outcome_t o;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d count %0d",
                 $time, st, cnt);
        mismatches++;
        return;
      end
      o = owed.pop_front();
      compare_field("status", o.st, st);
      compare_field("level_count", o.cnt, cnt);
      compare_field("entry_rate", o.r, r);
      compare_field("entry_volt", o.v, v);
    endfunction
  endclass

  level_table_tracker board;

  rate_voltage_table_patcher #(
    .DOMAINS(DOMAINS),
    .LEVELS (LEVELS)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .kind       (kind),
    .domain     (domain),
    .rate       (rate),
    .volt       (volt),
    .level_index(level_index),
    .done       (done),
    .status     (status),
    .level_count(level_count),
    .entry_rate (entry_rate),
    .entry_volt (entry_volt)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("** rate_voltage_table_patcher: FAILED **");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && done) board.check_result(status, level_count, entry_rate, entry_volt);
  end

  // Drives one item and returns once the transaction has been taken.
  task automatic send_item(input logic [1:0] k, input logic [3:0] d,
                           input logic [RATE_W-1:0] r, input logic [VOLT_W-1:0] v,
                           input logic [4:0] idx, input int idle_pct);
    @(negedge clk);
    if ($urandom_range(1, 100) <= idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    kind        = k;
    domain      = d;
    rate        = r;
    volt        = v;
    level_index = idx;
    start       = 1'b1;
    do @(posedge clk); while (busy);
    board.note_item(k, d, r, v, idx);
  endtask

  // A small pool of rates per table keeps updates and deletes frequent.
  function automatic logic [RATE_W-1:0] pick_rate();
    int unsigned p;
    p = $urandom_range(1, 100);
    if (p <= 65) return RATE_W'(1000 * $urandom_range(1, 48));
    if (p <= 90) return RATE_W'($urandom);
    if (p <= 95) return '0;
    return RATE_TOP;
  endfunction

  function automatic logic [VOLT_W-1:0] pick_volt();
    int unsigned p;
    p = $urandom_range(1, 100);
    if (p <= 15) return '0;
    if (p <= 55) return VOLT_W'($urandom_range(1, 16));
    if (p <= 60) return VOLT_W'($urandom_range(9990, 10000));
    if (p <= 90) return VOLT_W'($urandom_range(10001, 1500000));
    return VOLT_W'($urandom);
  endfunction

  task automatic random_item(input int idle_pct);
    int unsigned p;
    logic [1:0] k;
    logic [3:0] d;
    p = $urandom_range(1, 100);
    if (p <= 60) k = KIND_PATCH;
    else if (p <= 85) k = KIND_READ;
    else if (p <= 95) k = KIND_APPEND;
    else k = KIND_UNUSED;
    d = ($urandom_range(1, 100) <= 70) ? 4'($urandom_range(0, 3)) : 4'($urandom);
    send_item(k, d, pick_rate(), pick_volt(), 5'($urandom), idle_pct);
  endtask

  // Loads one table to capacity and then pushes against the limit.
  task automatic fill_table(input int idle_pct);
    logic [3:0] d;
    d = 4'($urandom);
    while (board.fill[d] < LEVELS)
      send_item(KIND_APPEND, d, pick_rate(), pick_volt(), '0, idle_pct);
    send_item(KIND_APPEND, d, pick_rate(), pick_volt(), '0, idle_pct);
    send_item(KIND_PATCH, d, RATE_W'($urandom_range(1, 999)), 21'd5, '0, idle_pct);
    send_item(KIND_READ, d, '0, '0, 5'd31, idle_pct);
  endtask

  initial begin
    int idle_pct [4];
    board = new();
    idle_pct = '{0, 53, 0, 24};
    rst = 1'b1;
    start = 1'b0;
    kind = KIND_PATCH;
    domain = '0;
    rate = '0;
    volt = '0;
    level_index = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Empty table, zero rate and an unknown kind.
    send_item(KIND_READ, 4'd0, '0, '0, 5'd0, 0);
    send_item(KIND_PATCH, 4'd0, '0, 21'd50, 5'd0, 0);
    send_item(KIND_UNUSED, 4'd0, 26'd5000, 21'd7, 5'd3, 0);
    // Inserts at the end, in front and in the middle, and an update; volt zero keeps the base.
    send_item(KIND_PATCH, 4'd0, 26'd5000, 21'd0, 5'd0, 0);
    send_item(KIND_PATCH, 4'd0, 26'd9000, 21'd10001, 5'd0, 0);
    send_item(KIND_PATCH, 4'd0, 26'd9000, 21'd1, 5'd0, 0);
    send_item(KIND_PATCH, 4'd0, 26'd7000, 21'd3, 5'd0, 0);
    // Saturation of absolute values and of step sums, then a delete and two more inserts.
    send_item(KIND_PATCH, 4'd0, RATE_TOP, VOLT_TOP, 5'd0, 0);
    send_item(KIND_PATCH, 4'd0, 26'd1, 21'd10000, 5'd0, 0);
    send_item(KIND_PATCH, 4'd0, 26'd7000, 21'd10000, 5'd0, 0);
    send_item(KIND_PATCH, 4'd0, 26'd9000, 21'd0, 5'd0, 0);
    send_item(KIND_PATCH, 4'd0, 26'd6000, 21'd0, 5'd0, 0);
    send_item(KIND_PATCH, 4'd0, 26'd1234, 21'd12500, 5'd0, 0);
    // Duplicate rates loaded by append: a patch acts on the first one.
    send_item(KIND_APPEND, 4'd15, 26'd300, VOLT_TOP, 5'd0, 0);
    send_item(KIND_APPEND, 4'd15, 26'd300, 21'd77, 5'd0, 0);
    send_item(KIND_APPEND, 4'd15, 26'd0, 21'd0, 5'd0, 0);
    send_item(KIND_PATCH, 4'd15, 26'd300, 21'd2, 5'd0, 0);
    send_item(KIND_READ, 4'd15, '0, '0, 5'd1, 0);
    send_item(KIND_READ, 4'd15, '0, '0, 5'd31, 0);
    send_item(KIND_PATCH, 4'd15, 26'd300, 21'd0, 5'd0, 0);
    for (int i = 0; i < 6; i++) send_item(KIND_READ, 4'd0, '0, '0, 5'(i), 0);

    for (int ph = 0; ph < 4; ph++) begin
      fill_table(idle_pct[ph]);
      repeat (170) random_item(idle_pct[ph]);
    end

    @(negedge clk);
    start = 1'b0;
    while (board.owed.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("** rate_voltage_table_patcher: PASSED **");
    end else begin
      $display("** rate_voltage_table_patcher: FAILED **");
    end
    $finish;
  end

endmodule
